### rtl/assert_macros.svh
// assertion macros for the slot timeout block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("check failed");
`define CHK_NEXT(lbl, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("check failed");
`else
`define CHK_IMPLY(lbl, rst, a, b)
`define CHK_NEXT(lbl, rst, a, b)
`endif
`endif

### rtl/stte_pkg.sv
package stte_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam int TIME_W = 48;
  localparam int DUR_W = 32;
  localparam int EV_W = 16;

  typedef enum logic [2:0] {
    CMD_ARM_RECV  = 3'd0,
    CMD_ARM_SEND  = 3'd1,
    CMD_POST      = 3'd2,
    CMD_SCAN_RECV = 3'd3,
    CMD_SCAN_SEND = 3'd4,
    CMD_POP       = 3'd5,
    CMD_READ      = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  localparam logic [1:0] REG_IN_DONE = 2'd0;
  localparam logic [1:0] REG_OUT_DONE = 2'd1;
  localparam logic [1:0] REG_RECV_TO = 2'd2;
  localparam logic [1:0] REG_SEND_TO = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_scan;
    logic scan_end;
  } sts_t;
endpackage

### rtl/stte_ctrl.sv
module stte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  stte_pkg::sts_t  sts,
  output stte_pkg::ctl_t  ctl
);
  stte_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= stte_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl = '0;
    busy = 1'b1;
    unique case (state)
      stte_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          state_next = stte_pkg::ST_EXEC;
        end
      end
      stte_pkg::ST_EXEC: begin
        if (sts.is_scan) begin
          ctl.scan_init = 1'b1;
          state_next = stte_pkg::ST_SCAN;
        end else begin
          ctl.exec = 1'b1;
          state_next = stte_pkg::ST_DONE;
        end
      end
      stte_pkg::ST_SCAN: begin
        if (sts.scan_end) state_next = stte_pkg::ST_DONE;
        else ctl.scan_step = 1'b1;
      end
      stte_pkg::ST_DONE: begin
        ctl.finish = 1'b1;
        state_next = stte_pkg::ST_IDLE;
      end
      default: state_next = stte_pkg::ST_IDLE;
    endcase
  end
endmodule

### rtl/stte_dp.sv
module stte_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  stte_pkg::ctl_t                     ctl,
  output stte_pkg::sts_t                     sts,
  input  logic [2:0]                         command,
  input  logic [stte_pkg::SLOT_W-1:0]        slot,
  input  logic [stte_pkg::TIME_W-1:0]        now,
  input  logic [stte_pkg::DUR_W-1:0]         duration,
  input  logic [stte_pkg::EV_W-1:0]          events,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_idx,
  input  logic [stte_pkg::EV_W-1:0]          cfg_data,
  output logic                               done,
  output logic                               status,
  output logic                               expired,
  output logic [stte_pkg::SLOT_W-1:0]        front_slot,
  output logic [stte_pkg::EV_W-1:0]          slot_events,
  output logic [stte_pkg::CNT_W-1:0]         signaled_count,
  output logic [stte_pkg::TIME_W-1:0]        next_recv_deadline,
  output logic [stte_pkg::TIME_W-1:0]        next_send_deadline
);
  localparam int N = stte_pkg::SLOTS;
  localparam int SW = stte_pkg::SLOT_W;
  localparam int CW = stte_pkg::CNT_W;
  localparam int TW = stte_pkg::TIME_W;
  localparam int EW = stte_pkg::EV_W;
  localparam logic [TW-1:0] TMAX = '1;

  // configuration
  logic [EW-1:0] in_done, out_done, recv_to, send_to;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_done <= EW'(1);
      out_done <= EW'(2);
      recv_to <= EW'(4);
      send_to <= EW'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        stte_pkg::REG_IN_DONE:  in_done <= cfg_data;
        stte_pkg::REG_OUT_DONE: out_done <= cfg_data;
        stte_pkg::REG_RECV_TO:  recv_to <= cfg_data;
        stte_pkg::REG_SEND_TO:  send_to <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched command
  stte_pkg::cmd_t cmd;
  logic [SW-1:0] s_reg;
  logic [TW-1:0] now_reg;
  logic [stte_pkg::DUR_W-1:0] dur_reg;
  logic [EW-1:0] ev_reg;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= stte_pkg::cmd_t'(command);
      s_reg <= slot;
      now_reg <= now;
      dur_reg <= duration;
      ev_reg <= events;
    end
  end

  // state arrays (two lists: index 0 recv, 1 send)
  logic [TW-1:0] dl [2][N];
  logic [SW-1:0] lst [2][N];
  logic [SW-1:0] plc [2][N];
  logic [N-1:0] armed [2];
  logic [CW-1:0] len [2];
  logic [TW-1:0] mind [2];
  logic [EW-1:0] sev [N];
  logic [N-1:0] sig;
  logic [SW-1:0] ring [N];
  logic [SW-1:0] rhead, rtail;
  logic [CW-1:0] rcount;

  // scan state
  logic which;
  logic [CW-1:0] idx;
  logic hit;

  assign sts.is_scan = (cmd == stte_pkg::CMD_SCAN_RECV) || (cmd == stte_pkg::CMD_SCAN_SEND);
  assign sts.scan_end = (idx >= len[which]);

  // saturating deadline
  logic [TW:0] dsum;
  logic [TW-1:0] dnew;
  assign dsum = {1'b0, now_reg} + {{(TW + 1 - stte_pkg::DUR_W){1'b0}}, dur_reg};
  assign dnew = dsum[TW] ? TMAX : dsum[TW-1:0];

  // scan element
  logic [SW-1:0] scur;
  logic [TW-1:0] dcur;
  assign scur = lst[which][idx[SW-1:0]];
  assign dcur = dl[which][scur];

  always_ff @(posedge clk) begin
    logic [SW-1:0] ps;
    logic [EW-1:0] pev;
    logic do_post;
    logic [1:0] rm;
    logic [CW-1:0] l;
    logic [SW-1:0] p, last;
    logic al;
    logic [CW-1:0] rc;
    logic [SW-1:0] rt;
    do_post = 1'b0;
    ps = s_reg;
    pev = ev_reg;
    rm = 2'b00;
    rc = rcount;
    rt = rtail;
    if (rst) begin
      armed[0] <= '0;
      armed[1] <= '0;
      len[0] <= '0;
      len[1] <= '0;
      mind[0] <= TMAX;
      mind[1] <= TMAX;
      for (int i = 0; i < N; i++) sev[i] <= '0;
      sig <= '0;
      rhead <= '0;
      rtail <= '0;
      rcount <= '0;
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.scan_init) begin
        which <= (cmd == stte_pkg::CMD_SCAN_SEND);
        mind[cmd == stte_pkg::CMD_SCAN_SEND] <= TMAX;
        idx <= '0;
        hit <= 1'b0;
      end
      if (ctl.exec) begin
        status <= 1'b0;
        expired <= 1'b0;
        front_slot <= '0;
        slot_events <= '0;
        unique case (cmd)
          stte_pkg::CMD_ARM_RECV, stte_pkg::CMD_ARM_SEND: begin
            al = (cmd == stte_pkg::CMD_ARM_SEND);
            dl[al][s_reg] <= dnew;
            if (!armed[al][s_reg]) begin
              armed[al][s_reg] <= 1'b1;
              plc[al][s_reg] <= len[al][SW-1:0];
              lst[al][len[al][SW-1:0]] <= s_reg;
              len[al] <= len[al] + CW'(1);
            end
            if (dnew < mind[al]) mind[al] <= dnew;
          end
          stte_pkg::CMD_POST: do_post = 1'b1;
          stte_pkg::CMD_POP: begin
            if (rcount == '0) status <= 1'b1;
            else begin
              front_slot <= ring[rhead];
              slot_events <= sev[ring[rhead]];
              sev[ring[rhead]] <= '0;
              sig[ring[rhead]] <= 1'b0;
              rhead <= rhead + SW'(1);
              rcount <= rcount - CW'(1);
            end
          end
          stte_pkg::CMD_READ: begin
            front_slot <= s_reg;
            slot_events <= sev[s_reg];
          end
          default: ;
        endcase
      end
      if (ctl.scan_step) begin
        if (dcur <= now_reg) begin
          hit <= 1'b1;
          ps = scur;
          pev = which ? send_to : recv_to;
          do_post = 1'b1;
          // remove from the scanned list; the post may remove from the other
          if (which) rm[1] = 1'b1; else rm[0] = 1'b1;
        end else begin
          if (dcur < mind[which]) mind[which] <= dcur;
          idx <= idx + CW'(1);
        end
      end
      if (ctl.finish && sts.is_scan) begin
        status <= 1'b0;
        expired <= hit;
        front_slot <= '0;
        slot_events <= '0;
      end
      // post: or in bits, enqueue once, done-mask removal
      if (do_post) begin
        sev[ps] <= sev[ps] | pev;
        if (!sig[ps]) begin
          sig[ps] <= 1'b1;
          ring[rt] <= ps;
          rtail <= rt + SW'(1);
          rcount <= rc + CW'(1);
        end
        if (|(pev & in_done)) rm[0] = 1'b1;
        if (|(pev & out_done)) rm[1] = 1'b1;
      end
      // swap removal on each list
      for (int k = 0; k < 2; k++) begin
        if (rm[k] && armed[k][ps] && len[k] != '0) begin
          l = len[k] - CW'(1);
          p = plc[k][ps];
          last = lst[k][l[SW-1:0]];
          len[k] <= l;
          lst[k][p] <= last;
          plc[k][last] <= p;
          armed[k][ps] <= 1'b0;
        end
      end
    end
  end

  assign signaled_count = rcount;
  assign next_recv_deadline = mind[0];
  assign next_send_deadline = mind[1];
endmodule

### rtl/slot_timeout_table_event_queue.sv
// arm, post, pop, read and unused codes: latched from IDLE, run in EXEC, then DONE sets the registered done
// scan: EXEC, then SCAN, which takes each entry of the scanned list in turn, then DONE
// throughput: one item at a time, a new start is taken in the cycle done is high
// reset: synchronous active-high rst empties lists and queue, minimums all ones
// results show for one cycle under done; the receiver cannot stall
`include "assert_macros.svh"
module slot_timeout_table_event_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         command,
  input  logic [stte_pkg::SLOT_W-1:0]        slot,
  input  logic [stte_pkg::TIME_W-1:0]        now,
  input  logic [stte_pkg::DUR_W-1:0]         duration,
  input  logic [stte_pkg::EV_W-1:0]          events,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_idx,
  input  logic [stte_pkg::EV_W-1:0]          cfg_data,
  output logic                               done,
  output logic                               status,
  output logic                               expired,
  output logic [stte_pkg::SLOT_W-1:0]        front_slot,
  output logic [stte_pkg::EV_W-1:0]          slot_events,
  output logic [stte_pkg::CNT_W-1:0]         signaled_count,
  output logic [stte_pkg::TIME_W-1:0]        next_recv_deadline,
  output logic [stte_pkg::TIME_W-1:0]        next_send_deadline
);
  stte_pkg::ctl_t ctl;
  stte_pkg::sts_t sts;

  stte_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .ctl);

  stte_dp u_dp (
    .clk, .rst, .ctl, .sts, .command, .slot, .now, .duration, .events,
    .cfg_we, .cfg_idx, .cfg_data, .done, .status, .expired, .front_slot,
    .slot_events, .signaled_count, .next_recv_deadline, .next_send_deadline
  );

  `CHK_NEXT(a_start_busy, rst, start && !busy, busy)
  `CHK_IMPLY(a_count_max, rst, 1'b1, signaled_count <= 5'd16)
  `CHK_NEXT(a_done_one, rst, done, !done)
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import stte_pkg::*;

  localparam logic [TIME_W-1:0] NEVER = '1;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [2:0] command = 0;
  logic [SLOT_W-1:0] slot = 0;
  logic [TIME_W-1:0] now = 0;
  logic [DUR_W-1:0] duration = 0;
  logic [EV_W-1:0] events = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = 0;
  logic [EV_W-1:0] cfg_data = 0;
  logic done, status, expired;
  logic [SLOT_W-1:0] front_slot;
  logic [EV_W-1:0] slot_events;
  logic [CNT_W-1:0] signaled_count;
  logic [TIME_W-1:0] next_recv_deadline, next_send_deadline;

  slot_timeout_table_event_queue uut (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic status;
    logic expired;
    logic [SLOT_W-1:0] front;
    logic [EV_W-1:0] sev;
    logic [CNT_W-1:0] cnt;
    logic [TIME_W-1:0] recv_min;
    logic [TIME_W-1:0] send_min;
  } outcome_t;

  typedef struct {
    cmd_t cmd;
    logic [SLOT_W-1:0] s;
    logic [TIME_W-1:0] t;
    logic [DUR_W-1:0] d;
    logic [EV_W-1:0] ev;
    bit typed;
    logic t_status;
    logic [SLOT_W-1:0] t_front;
    logic [EV_W-1:0] t_sev;
    logic [TIME_W-1:0] t_recv;
    logic [TIME_W-1:0] t_send;
  } row_t;

  // shadow of the block: index 0 is the receive list, 1 the send list
  logic [TIME_W-1:0] due_at[2][SLOTS];
  logic [SLOT_W-1:0] active[2][SLOTS];
  int active_len[2];
  bit is_armed[2][SLOTS];
  int where[2][SLOTS];
  logic [TIME_W-1:0] min_due[2];
  logic [EV_W-1:0] ev_bits[SLOTS];
  bit queued[SLOTS];
  logic [SLOT_W-1:0] ring[SLOTS];
  int ring_rd, ring_wr, ring_cnt;
  logic [EV_W-1:0] masks[4];

  outcome_t pending[$];
  int errors = 0;
  int results_seen = 0;
  int scans_hit = 0;
  int gap_pct = 0;
  logic [TIME_W-1:0] clock_now = 0;

  function void unlink(int k, int s);
    int p;
    logic [SLOT_W-1:0] last;
    if (!is_armed[k][s] || active_len[k] == 0) return;
    p = where[k][s];
    active_len[k]--;
    last = active[k][active_len[k]];
    active[k][p] = last;
    where[k][last] = p;
    is_armed[k][s] = 0;
  endfunction

  function void arm_deadline(int k, int s, logic [TIME_W-1:0] t, logic [DUR_W-1:0] d);
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] due;
    sum = {1'b0, t} + d;
    due = sum[TIME_W] ? NEVER : sum[TIME_W-1:0];
    due_at[k][s] = due;
    if (!is_armed[k][s] && active_len[k] < SLOTS) begin
      is_armed[k][s] = 1;
      where[k][s] = active_len[k];
      active[k][active_len[k]] = s;
      active_len[k]++;
    end
    if (due < min_due[k]) min_due[k] = due;
  endfunction

  function void signal_slot(int s, logic [EV_W-1:0] ev);
    ev_bits[s] |= ev;
    if (!queued[s] && ring_cnt < SLOTS) begin
      queued[s] = 1;
      ring[ring_wr] = s;
      ring_wr = (ring_wr + 1) % SLOTS;
      ring_cnt++;
    end
    if (ev & masks[REG_IN_DONE]) unlink(0, s);
    if (ev & masks[REG_OUT_DONE]) unlink(1, s);
  endfunction

  function bit sweep_expired(int k, logic [TIME_W-1:0] t, logic [EV_W-1:0] bits);
    int i;
    int s;
    bit hit;
    i = 0;
    hit = 0;
    min_due[k] = NEVER;
    while (i < active_len[k]) begin
      s = active[k][i];
      if (due_at[k][s] <= t) begin
        hit = 1;
        unlink(k, s);
        signal_slot(s, bits);
      end else begin
        if (due_at[k][s] < min_due[k]) min_due[k] = due_at[k][s];
        i++;
      end
    end
    return hit;
  endfunction

  function outcome_t apply_command(cmd_t c, int s, logic [TIME_W-1:0] t,
                                   logic [DUR_W-1:0] d, logic [EV_W-1:0] ev);
    outcome_t o;
    int v;
    o = '{default: 0};
    case (c)
      CMD_ARM_RECV: arm_deadline(0, s, t, d);
      CMD_ARM_SEND: arm_deadline(1, s, t, d);
      CMD_POST: signal_slot(s, ev);
      CMD_SCAN_RECV: o.expired = sweep_expired(0, t, masks[REG_RECV_TO]);
      CMD_SCAN_SEND: o.expired = sweep_expired(1, t, masks[REG_SEND_TO]);
      CMD_POP: begin
        if (ring_cnt == 0) begin
          o.status = 1;
        end else begin
          v = ring[ring_rd];
          o.front = v;
          o.sev = ev_bits[v];
          ev_bits[v] = 0;
          queued[v] = 0;
          ring_rd = (ring_rd + 1) % SLOTS;
          ring_cnt--;
        end
      end
      CMD_READ: begin
        o.front = s;
        o.sev = ev_bits[s];
      end
      default: ;
    endcase
    o.cnt = ring_cnt;
    o.recv_min = min_due[0];
    o.send_min = min_due[1];
    return o;
  endfunction

  // hand one item to the block and work out what it should answer
  task automatic issue(cmd_t c, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] t,
                       logic [DUR_W-1:0] d, logic [EV_W-1:0] ev, output outcome_t o);
    command <= c;
    slot <= s;
    now <= t;
    duration <= d;
    events <= ev;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    o = apply_command(c, s, t, d, ev);
    if (c == CMD_SCAN_RECV || c == CMD_SCAN_SEND) scans_hit += o.expired;
  endtask

  // sender idle cycles between items
  task automatic idle_gap();
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [EV_W-1:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    masks[idx] = val;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        outcome_t e;
        e = pending.pop_front();
        check_field("status", e.status, status);
        check_field("expired", e.expired, expired);
        check_field("front_slot", e.front, front_slot);
        check_field("slot_events", e.sev, slot_events);
        check_field("signaled_count", e.cnt, signaled_count);
        check_field("next_recv_deadline", e.recv_min, next_recv_deadline);
        check_field("next_send_deadline", e.send_min, next_send_deadline);
      end
    end
  end

  // random item with a coherent time base
  task automatic random_item();
    int pick;
    cmd_t c;
    logic [DUR_W-1:0] d;
    logic [EV_W-1:0] ev;
    logic [TIME_W-1:0] t;
    outcome_t o;
    pick = $urandom_range(99);
    if ($urandom_range(31) == 0)
      clock_now = {$urandom, $urandom} & NEVER;
    else if ($urandom_range(63) == 0)
      clock_now = NEVER - $urandom_range(500);
    else
      clock_now = clock_now + $urandom_range(120);
    t = clock_now;
    if ($urandom_range(15) == 0) d = $urandom;
    else d = $urandom_range(400);
    if ($urandom_range(3) == 0) ev = $urandom;
    else ev = 1 << $urandom_range(4);
    if (pick < 20) c = CMD_ARM_RECV;
    else if (pick < 38) c = CMD_ARM_SEND;
    else if (pick < 52) c = CMD_POST;
    else if (pick < 63) c = CMD_SCAN_RECV;
    else if (pick < 74) c = CMD_SCAN_SEND;
    else if (pick < 87) c = CMD_POP;
    else if (pick < 97) c = CMD_READ;
    else c = CMD_NOP;
    issue(c, $urandom_range(SLOTS - 1), t, d, ev, o);
    pending.push_back(o);
    idle_gap();
  endtask

  row_t plan[22];
  logic [EV_W-1:0] cfg_sets[6][4];
  int items_sent = 0;

  initial begin
    outcome_t o;
    // reset state of the shadow
    foreach (min_due[k]) min_due[k] = NEVER;
    active_len = '{0, 0};
    foreach (is_armed[k, s]) is_armed[k][s] = 0;
    foreach (ev_bits[s]) begin
      ev_bits[s] = 0;
      queued[s] = 0;
    end
    ring_rd = 0;
    ring_wr = 0;
    ring_cnt = 0;
    masks = '{16'd1, 16'd2, 16'd4, 16'd8};

    // directed items: typed rows carry their answer, the rest use the shadow
    plan[0] = '{CMD_POP, 0, 0, 0, 0, 1, 1, 0, 0, NEVER, NEVER};
    plan[1] = '{CMD_READ, 15, 0, 0, 0, 1, 0, 15, 0, NEVER, NEVER};
    plan[2] = '{CMD_ARM_RECV, 0, NEVER, 32'hFFFFFFFF, 0, 1, 0, 0, 0, NEVER, NEVER};
    plan[3] = '{CMD_ARM_SEND, 15, 0, 0, 0, 1, 0, 0, 0, NEVER, 0};
    plan[4] = '{CMD_ARM_RECV, 1, 100, 50, 0, 0, 0, 0, 0, 0, 0};
    plan[5] = '{CMD_ARM_RECV, 2, 100, 10, 0, 0, 0, 0, 0, 0, 0};
    plan[6] = '{CMD_ARM_SEND, 3, 1000, 5, 0, 0, 0, 0, 0, 0, 0};
    plan[7] = '{CMD_ARM_RECV, 1, 100, 30, 0, 0, 0, 0, 0, 0, 0};
    plan[8] = '{CMD_SCAN_RECV, 0, 120, 0, 0, 0, 0, 0, 0, 0, 0};
    plan[9] = '{CMD_SCAN_SEND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    plan[10] = '{CMD_POST, 1, 0, 0, 16'h0001, 0, 0, 0, 0, 0, 0};
    plan[11] = '{CMD_POST, 3, 0, 0, 16'h0002, 0, 0, 0, 0, 0, 0};
    plan[12] = '{CMD_SCAN_RECV, 0, NEVER, 0, 0, 0, 0, 0, 0, 0, 0};
    plan[13] = '{CMD_SCAN_SEND, 0, NEVER, 0, 0, 0, 0, 0, 0, 0, 0};
    plan[14] = '{CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    plan[15] = '{CMD_POST, 7, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0};
    plan[16] = '{CMD_POST, 5, 0, 0, 16'h0000, 0, 0, 0, 0, 0, 0};
    plan[17] = '{CMD_NOP, 9, NEVER, 32'hFFFFFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0};
    for (int i = 18; i < 22; i++) plan[i] = '{CMD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    // register settings per phase, extremes among them
    cfg_sets[0] = '{16'd1, 16'd2, 16'd4, 16'd8};
    cfg_sets[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    cfg_sets[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    cfg_sets[3] = '{16'h0001, 16'h0002, 16'h0006, 16'h0009};
    cfg_sets[4] = '{$urandom, $urandom, $urandom, $urandom};
    cfg_sets[5] = '{16'h5555, 16'hAAAA, 16'h8001, 16'h0C30};

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (plan[i]) begin
      issue(plan[i].cmd, plan[i].s, plan[i].t, plan[i].d, plan[i].ev, o);
      if (plan[i].typed)
        o = '{plan[i].t_status, 1'b0, plan[i].t_front, plan[i].t_sev, 5'd0,
              plan[i].t_recv, plan[i].t_send};
      pending.push_back(o);
      items_sent++;
      idle_gap();
    end
    drain();

    // random phases, registers rewritten while idle
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(2'(r), cfg_sets[ph][r]);
      cfg_we <= 0;
      gap_pct = (ph % 3 == 0) ? 11 : (ph % 3 == 1) ? 82 : 0;
      for (int n = 0; n < 135; n++) begin
        random_item();
        items_sent++;
      end
      drain();
    end

    $display("%0d items over 6 register settings, %0d results, %0d scans with expiry",
             items_sent, results_seen, scans_hit);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/stte_pkg.sv
rtl/stte_ctrl.sv
rtl/stte_dp.sv
rtl/slot_timeout_table_event_queue.sv
tb/tb_top.sv
